[rtl/b64sd_pkg.sv]
// Shared types, codes and helper functions for the strict base64 stream decoder.
// No dependencies; every other file refers to this package by scoped names.
package b64sd_pkg;

  // Status codes, as they appear on the status word of a text.
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_CHAR = 2'd1,
    ST_BAD_LEN  = 2'd2,
    ST_NONCANON = 2'd3
  } status_t;

  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  localparam logic [7:0] CHAR_PAD = 8'h3D;  // '='

  localparam int MAX_RESULTS = 4;
  localparam int COUNT_W     = $clog2(MAX_RESULTS + 1);

  // One output word.
  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
    status_t    status;
    logic       end_mark;
  } result_t;

  // Results produced by one input word, handed to the output queue.
  typedef struct packed {
    logic [COUNT_W-1:0]            count;
    result_t [MAX_RESULTS-1:0]     item;
  } batch_t;

  // Character to sextet lookup; bit 6 is set when the character is in the alphabet.
  function automatic logic [6:0] sextet_of(input logic [7:0] c, input logic url);
    logic [6:0] r;
    r = 7'd0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = {1'b1, 6'(c - 8'h41)};
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      r = {1'b1, 6'(c - 8'h61 + 8'd26)};
    end else if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 6'(c - 8'h30 + 8'd52)};
    end else if (url && c == 8'h2D) begin
      r = {1'b1, 6'd62};
    end else if (url && c == 8'h5F) begin
      r = {1'b1, 6'd63};
    end else if (!url && c == 8'h2B) begin
      r = {1'b1, 6'd62};
    end else if (!url && c == 8'h2F) begin
      r = {1'b1, 6'd63};
    end
    return r;
  endfunction

  // Priority of an error: bad length over invalid character over non-canonical bits.
  function automatic logic [1:0] rank_of(input status_t s);
    logic [1:0] r;
    unique case (s)
      ST_BAD_LEN:  r = 2'd3;
      ST_BAD_CHAR: r = 2'd2;
      ST_NONCANON: r = 2'd1;
      default:     r = 2'd0;
    endcase
    return r;
  endfunction

  // Sticky error update: the new code wins only when it ranks higher.
  function automatic status_t raise_err(input status_t cur, input status_t code);
    return (rank_of(code) > rank_of(cur)) ? code : cur;
  endfunction

endpackage

[rtl/base64_strict_stream_decoder.sv]
// Top level of the strict base64 stream decoder: configuration register and wiring.
// Depends on b64sd_pkg, b64sd_core and b64sd_outq.

// Strict base64 (RFC 4648) decoder, one character word in per cycle. Each input word is a
// raw character byte with tlast marking the final character of a text. The url_mode
// register selects the standard alphabet with required padding (0) or the URL-safe alphabet
// without padding (1); write it only between texts. Output words carry either a decoded
// byte (tuser 0) or, after the last character, one status word (tuser 1, tlast 1) whose
// status field is 0 ok, 1 invalid character, 2 bad length or padding, 3 non-canonical pad
// bits. Bytes of a group are sent as the group completes and stop at the first error, so a
// consumer keeps the bytes of a text only when its status is ok. An accepted character is
// registered, and its results queued, before the first output word. A character is accepted
// every cycle; a completed group or the last character loads up to four result words into
// the output queue at once, and that queue drains one word per cycle, so a character that
// yields results waits until the queue is empty or about to empty. In a steady stream the
// three bytes of a group drain while the next three characters are taken, which keeps the
// input at one character per cycle as long as the output side takes a word every cycle.
module base64_strict_stream_decoder (
  input  logic        clk,
  input  logic        rst,
  // Configuration.
  input  logic        cfg_we,
  input  logic        cfg_wdata,      // url_mode
  // Character input.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
  input  logic        s_axis_tlast,   // is_last
  // Result output.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] data_byte, [9:8] status, [15:10] zero
  output logic        m_axis_tuser,   // kind
  output logic        m_axis_tlast    // end_mark
);

  logic               url_mode;
  logic               q_free;
  logic               push;
  b64sd_pkg::batch_t  batch;
  b64sd_pkg::result_t out_item;

  // Mode register; the decode logic samples it as each character is consumed.
  always_ff @(posedge clk) begin
    if (rst) begin
      url_mode <= 1'b0;
    end else if (cfg_we) begin
      url_mode <= cfg_wdata;
    end
  end

  b64sd_core u_core (
    .clk      (clk),
    .rst      (rst),
    .url_mode (url_mode),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_char  (s_axis_tdata),
    .in_last  (s_axis_tlast),
    .q_free   (q_free),
    .push     (push),
    .batch    (batch)
  );

  b64sd_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .batch     (batch),
    .q_free    (q_free),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_item  (out_item)
  );

  assign m_axis_tdata = {6'd0, out_item.status, out_item.data_byte};
  assign m_axis_tuser = out_item.kind;
  assign m_axis_tlast = out_item.end_mark;

endmodule

[rtl/b64sd_core.sv]
// Input register, per-text decode state and the decode logic of one character.
// Depends on b64sd_pkg; hands its results to b64sd_outq as a batch_t.
module b64sd_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                url_mode,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_char,
  input  logic                in_last,
  input  logic                q_free,
  output logic                push,
  output b64sd_pkg::batch_t   batch
);

  logic        hold_valid;
  logic [7:0]  hold_char;
  logic        hold_last;

  logic [1:0]          group_position;
  logic [17:0]         sextet_accumulator;
  logic                pad_seen;
  b64sd_pkg::status_t  error_code;
  logic                group_after_pad;

  logic [1:0]          group_position_next;
  logic [17:0]         sextet_accumulator_next;
  logic                pad_seen_next;
  b64sd_pkg::status_t  error_code_next;
  logic                group_after_pad_next;

  logic consume;

  always_comb begin
    logic [6:0]                    sx;
    logic [5:0]                    v;
    logic                          is_pad;
    logic [23:0]                   val;
    logic [1:0]                    nbytes;
    logic                          padded;
    b64sd_pkg::status_t            e;
    logic [b64sd_pkg::COUNT_W-1:0] n;
    b64sd_pkg::result_t            r;

    e      = error_code;
    n      = '0;
    r      = '0;
    is_pad = (hold_char == b64sd_pkg::CHAR_PAD);
    sx     = b64sd_pkg::sextet_of(hold_char, url_mode);
    v      = 6'd0;
    val    = 24'd0;
    nbytes = 2'd3;
    padded = 1'b0;
    batch  = '0;

    group_position_next     = group_position;
    sextet_accumulator_next = sextet_accumulator;
    pad_seen_next           = pad_seen;
    group_after_pad_next    = group_after_pad;

    if (url_mode) begin
      if (is_pad) begin
        e = b64sd_pkg::raise_err(e, b64sd_pkg::ST_BAD_LEN);
      end else if (!sx[6]) begin
        e = b64sd_pkg::raise_err(e, b64sd_pkg::ST_BAD_CHAR);
      end else begin
        v = sx[5:0];
      end
    end else begin
      if (group_after_pad) e = b64sd_pkg::raise_err(e, b64sd_pkg::ST_BAD_CHAR);
      if (is_pad) begin
        // Padding may only stand in the last two places of a group.
        if (group_position < 2'd2) e = b64sd_pkg::raise_err(e, b64sd_pkg::ST_BAD_CHAR);
      end else begin
        if (!sx[6]) begin
          e = b64sd_pkg::raise_err(e, b64sd_pkg::ST_BAD_CHAR);
        end else begin
          v = sx[5:0];
        end
        // A data character after a pad in the third place is misplaced.
        if (group_position == 2'd3 && pad_seen) begin
          e = b64sd_pkg::raise_err(e, b64sd_pkg::ST_BAD_CHAR);
        end
      end
    end

    if (group_position == 2'd3) begin
      val = {sextet_accumulator, v};
      if (!url_mode) begin
        if (is_pad) begin
          padded = 1'b1;
          if (pad_seen) begin
            nbytes = 2'd1;
            if (sextet_accumulator[9:6] != 4'd0) begin
              e = b64sd_pkg::raise_err(e, b64sd_pkg::ST_NONCANON);
            end
          end else begin
            nbytes = 2'd2;
            if (sextet_accumulator[1:0] != 2'd0) begin
              e = b64sd_pkg::raise_err(e, b64sd_pkg::ST_NONCANON);
            end
          end
        end else if (pad_seen) begin
          padded = 1'b1;
        end
      end
      if (e == b64sd_pkg::ST_OK) begin
        r = '{kind: b64sd_pkg::KIND_DATA, data_byte: val[23:16],
              status: b64sd_pkg::ST_OK, end_mark: 1'b0};
        batch.item[n[1:0]] = r;
        n = n + 1'b1;
        if (nbytes >= 2'd2) begin
          r.data_byte = val[15:8];
          batch.item[n[1:0]] = r;
          n = n + 1'b1;
        end
        if (nbytes == 2'd3) begin
          r.data_byte = val[7:0];
          batch.item[n[1:0]] = r;
          n = n + 1'b1;
        end
      end
      if (padded) group_after_pad_next = 1'b1;
      sextet_accumulator_next = 18'd0;
      pad_seen_next           = 1'b0;
      group_position_next     = 2'd0;
    end else begin
      if (!url_mode && is_pad && group_position == 2'd2) pad_seen_next = 1'b1;
      sextet_accumulator_next = {sextet_accumulator[11:0], v};
      group_position_next     = group_position + 2'd1;
    end

    if (hold_last) begin
      if (!url_mode) begin
        if (group_position_next != 2'd0) e = b64sd_pkg::raise_err(e, b64sd_pkg::ST_BAD_LEN);
      end else if (group_position_next == 2'd1) begin
        e = b64sd_pkg::raise_err(e, b64sd_pkg::ST_BAD_LEN);
      end else if (group_position_next == 2'd2) begin
        // Two-character tail: one byte, low four bits must be zero.
        if (sextet_accumulator_next[3:0] != 4'd0) begin
          e = b64sd_pkg::raise_err(e, b64sd_pkg::ST_NONCANON);
        end
        if (e == b64sd_pkg::ST_OK) begin
          r = '{kind: b64sd_pkg::KIND_DATA, data_byte: sextet_accumulator_next[11:4],
                status: b64sd_pkg::ST_OK, end_mark: 1'b0};
          batch.item[n[1:0]] = r;
          n = n + 1'b1;
        end
      end else if (group_position_next == 2'd3) begin
        // Three-character tail: two bytes, low two bits must be zero.
        if (sextet_accumulator_next[1:0] != 2'd0) begin
          e = b64sd_pkg::raise_err(e, b64sd_pkg::ST_NONCANON);
        end
        if (e == b64sd_pkg::ST_OK) begin
          r = '{kind: b64sd_pkg::KIND_DATA, data_byte: sextet_accumulator_next[17:10],
                status: b64sd_pkg::ST_OK, end_mark: 1'b0};
          batch.item[n[1:0]] = r;
          n = n + 1'b1;
          r.data_byte = sextet_accumulator_next[9:2];
          batch.item[n[1:0]] = r;
          n = n + 1'b1;
        end
      end
      r = '{kind: b64sd_pkg::KIND_STATUS, data_byte: 8'd0, status: e, end_mark: 1'b1};
      batch.item[n[1:0]] = r;
      n = n + 1'b1;
      group_position_next     = 2'd0;
      sextet_accumulator_next = 18'd0;
      pad_seen_next           = 1'b0;
      group_after_pad_next    = 1'b0;
      e                       = b64sd_pkg::ST_OK;
    end

    error_code_next = e;
    batch.count     = n;
  end

  // A word that yields no result never waits for the output queue.
  assign consume  = hold_valid && (batch.count == '0 || q_free);
  assign push     = consume && (batch.count != '0);
  assign in_ready = !hold_valid || consume;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid         <= 1'b0;
      group_position     <= 2'd0;
      sextet_accumulator <= 18'd0;
      pad_seen           <= 1'b0;
      error_code         <= b64sd_pkg::ST_OK;
      group_after_pad    <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        hold_valid <= 1'b1;
      end else if (consume) begin
        hold_valid <= 1'b0;
      end
      if (consume) begin
        group_position     <= group_position_next;
        sextet_accumulator <= sextet_accumulator_next;
        pad_seen           <= pad_seen_next;
        error_code         <= error_code_next;
        group_after_pad    <= group_after_pad_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_char <= in_char;
      hold_last <= in_last;
    end
  end

  // A last character always ends its text with a clean state.
  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    consume && hold_last |=> group_position == 2'd0 && error_code == b64sd_pkg::ST_OK
      && !group_after_pad)
    else $error("text state not cleared after last character");

  // The status result appears exactly when a last character is consumed.
  a_status_on_last: assert property (@(posedge clk) disable iff (rst)
    consume && hold_last |-> batch.item[batch.count[1:0] - 2'd1].end_mark)
    else $error("last character did not produce a status result");

endmodule

[rtl/b64sd_outq.sv]
// Output queue: holds the results of one decoded character; hands one out per ready cycle.
// Depends on b64sd_pkg for result_t and batch_t.
module b64sd_outq (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  b64sd_pkg::batch_t  batch,
  output logic               q_free,
  output logic               out_valid,
  input  logic               out_ready,
  output b64sd_pkg::result_t out_item
);

  b64sd_pkg::result_t [b64sd_pkg::MAX_RESULTS-1:0] slot;
  logic [b64sd_pkg::COUNT_W-1:0]                   cnt;
  logic                                            fire;

  assign out_valid = (cnt != '0);
  assign fire      = out_valid && out_ready;
  assign out_item  = slot[0];
  // The queue takes a new batch when empty or when its last word leaves this cycle.
  assign q_free    = (cnt == '0) || (cnt == b64sd_pkg::COUNT_W'(1) && out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (push) begin
      cnt <= batch.count;
    end else if (fire) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot <= batch.item;
    end else if (fire) begin
      for (int i = 0; i < b64sd_pkg::MAX_RESULTS - 1; i++) begin
        slot[i] <= slot[i+1];
      end
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    push |-> cnt == '0 || (cnt == b64sd_pkg::COUNT_W'(1) && fire))
    else $error("batch pushed over results not yet taken");

  a_status_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.end_mark |-> out_item.kind == b64sd_pkg::KIND_STATUS
      && out_item.data_byte == 8'd0)
    else $error("end mark on a data result");

endmodule

[sim/tb.sv]
// Self-checking testbench for the strict base64 stream decoder (standard and URL alphabets).
// Depends on b64sd_pkg and base64_strict_stream_decoder; a built-in predictor checks results.

module tb;

  localparam logic MODE_STD = 1'b0;
  localparam logic MODE_URL = 1'b1;

  // A directed row either trusts the predictor or carries its own expected status word.
  localparam logic CHECK_PRED  = 1'b0;
  localparam logic CHECK_TYPED = 1'b1;

  localparam int DRAIN_CYCLES = 8;       // a little over the hold register and output queue
  localparam int PHASES       = 6;
  localparam int PHASE_CHARS  = 52;      // with the directed rows, about 360 characters
  localparam int LIMIT_TIME   = 800000;  // far above the slowest legal run
  localparam int REPORT_CAP   = 40;

  typedef enum int {RX_ALWAYS, RX_MOSTLY, RX_SPARSE, RX_ALTERNATE} rx_style_t;

  typedef enum int {
    BREAK_NOISE, BREAK_BYTE, BREAK_PAD, BREAK_EXTRA, BREAK_GROUP, BREAK_ALPHABET
  } break_kind_t;

  typedef struct packed {
    logic               mode;
    logic [7:0]         code;
    logic               last;
    logic               typed;
    b64sd_pkg::status_t status;
  } dir_row_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic        cfg_wdata;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [7:0] char_code
  logic        s_axis_tlast;   // is_last
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;   // [7:0] data_byte, [9:8] status, [15:10] zero
  logic        m_axis_tuser;   // kind
  logic        m_axis_tlast;   // end_mark

  base64_strict_stream_decoder DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // The directed texts. Each text ends on the row whose last bit is set. Rows with a typed
  // status end a text whose final word is only the status word, so it can be read directly.
  dir_row_t dir_table [26] = '{
    // Standard alphabet: '+' and '/' at the top of the range, three bytes.
    {MODE_STD, "+",   1'b0, CHECK_PRED,  b64sd_pkg::ST_OK},
    {MODE_STD, "/",   1'b0, CHECK_PRED,  b64sd_pkg::ST_OK},
    {MODE_STD, "/",   1'b0, CHECK_PRED,  b64sd_pkg::ST_OK},
    {MODE_STD, "/",   1'b1, CHECK_PRED,  b64sd_pkg::ST_OK},
    // Two pad characters with clean leftover bits: one zero byte.
    {MODE_STD, "A",   1'b0, CHECK_PRED,  b64sd_pkg::ST_OK},
    {MODE_STD, "A",   1'b0, CHECK_PRED,  b64sd_pkg::ST_OK},
    {MODE_STD, "=",   1'b0, CHECK_PRED,  b64sd_pkg::ST_OK},
    {MODE_STD, "=",   1'b1, CHECK_PRED,  b64sd_pkg::ST_OK},
    // One pad character but the third sextet leaves a set bit behind.
    {MODE_STD, "A",   1'b0, CHECK_PRED,  b64sd_pkg::ST_OK},
    {MODE_STD, "A",   1'b0, CHECK_PRED,  b64sd_pkg::ST_OK},
    {MODE_STD, "B",   1'b0, CHECK_PRED,  b64sd_pkg::ST_OK},
    {MODE_STD, "=",   1'b1, CHECK_TYPED, b64sd_pkg::ST_NONCANON},
    // A text of one character is not a whole group.
    {MODE_STD, "A",   1'b1, CHECK_TYPED, b64sd_pkg::ST_BAD_LEN},
    // Pad at the head of a group, then the byte extremes, none of them in the alphabet.
    {MODE_STD, "=",   1'b0, CHECK_PRED,  b64sd_pkg::ST_OK},
    {MODE_STD, 8'hFF, 1'b0, CHECK_PRED,  b64sd_pkg::ST_OK},
    {MODE_STD, 8'h00, 1'b0, CHECK_PRED,  b64sd_pkg::ST_OK},
    {MODE_STD, 8'h80, 1'b1, CHECK_TYPED, b64sd_pkg::ST_BAD_CHAR},
    // URL alphabet: a two-character tail whose last sextet has low bits set.
    {MODE_URL, "-",   1'b0, CHECK_PRED,  b64sd_pkg::ST_OK},
    {MODE_URL, "_",   1'b1, CHECK_TYPED, b64sd_pkg::ST_NONCANON},
    // A pad character is never allowed in URL mode.
    {MODE_URL, "A",   1'b0, CHECK_PRED,  b64sd_pkg::ST_OK},
    {MODE_URL, "=",   1'b1, CHECK_TYPED, b64sd_pkg::ST_BAD_LEN},
    // Clean two-character tail: one byte of all ones.
    {MODE_URL, "_",   1'b0, CHECK_PRED,  b64sd_pkg::ST_OK},
    {MODE_URL, "w",   1'b1, CHECK_PRED,  b64sd_pkg::ST_OK},
    // Clean three-character tail: two bytes.
    {MODE_URL, "z",   1'b0, CHECK_PRED,  b64sd_pkg::ST_OK},
    {MODE_URL, "9",   1'b0, CHECK_PRED,  b64sd_pkg::ST_OK},
    {MODE_URL, "8",   1'b1, CHECK_PRED,  b64sd_pkg::ST_OK}
  };

  // Decoder state as the testbench sees it; all but url_sel clear after each text.
  logic               url_sel;
  logic [1:0]         grp_pos;
  logic [17:0]        sextets;
  logic               pad_at2;
  b64sd_pkg::status_t text_err;
  logic               pad_group_done;

  b64sd_pkg::result_t step_words [4];   // words caused by the character just decoded
  b64sd_pkg::result_t decoded_q [$];    // words still to come out of the block, oldest first
  logic [7:0]         text_q [$];       // characters of the text being built

  int burst_left;
  int mismatches;
  int chars_sent;
  int texts_sent;
  int words_checked;
  int bad_texts;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #(LIMIT_TIME);
    $display("TEST FAILED");
    $finish;
  end

  task automatic report(input string what, input int want, input int got);
    if (mismatches < REPORT_CAP)
      $display("ERROR at %0t: %s, expected %0h, got %0h", $time, what, want, got);
    mismatches++;
  endtask

  function automatic logic [1:0] err_weight(input b64sd_pkg::status_t s);
    case (s)
      b64sd_pkg::ST_BAD_LEN:  return 2'd3;
      b64sd_pkg::ST_BAD_CHAR: return 2'd2;
      b64sd_pkg::ST_NONCANON: return 2'd1;
      default:                return 2'd0;
    endcase
  endfunction

  // The stored error is sticky and only a stronger one replaces it.
  function automatic void bump_err(input b64sd_pkg::status_t code);
    if (err_weight(code) > err_weight(text_err)) text_err = code;
  endfunction

  // Bit 6 flags a character that belongs to the selected alphabet.
  function automatic logic [6:0] alphabet_value(input logic [7:0] c, input logic url);
    if (c >= "A" && c <= "Z") return {1'b1, 6'(c - "A")};
    if (c >= "a" && c <= "z") return {1'b1, 6'(c - "a" + 8'd26)};
    if (c >= "0" && c <= "9") return {1'b1, 6'(c - "0" + 8'd52)};
    if (c == (url ? "-" : "+")) return {1'b1, 6'd62};
    if (c == (url ? "_" : "/")) return {1'b1, 6'd63};
    return 7'd0;
  endfunction

  function automatic logic [7:0] char_for(input logic [5:0] v, input logic url);
    if (v < 6'd26) return 8'("A" + v);
    if (v < 6'd52) return 8'("a" + v - 8'd26);
    if (v < 6'd62) return 8'("0" + v - 8'd52);
    if (v == 6'd62) return url ? "-" : "+";
    return url ? "_" : "/";
  endfunction

  // Advances the decoder state by one character and fills step_words with what it emits.
  function automatic int decode_char(input logic [7:0] c, input logic last);
    logic [6:0]  lk;
    logic [5:0]  v;
    logic [1:0]  pos;
    logic [23:0] grp;
    int          nbytes;
    logic        padded;
    int          n;
    n = 0;
    pos = grp_pos;
    v = 6'd0;
    lk = alphabet_value(c, url_sel);
    if (url_sel) begin
      if (c == b64sd_pkg::CHAR_PAD) begin
        bump_err(b64sd_pkg::ST_BAD_LEN);
      end else if (!lk[6]) begin
        bump_err(b64sd_pkg::ST_BAD_CHAR);
      end else begin
        v = lk[5:0];
      end
    end else begin
      // Anything after a padded group, or a pad too early in a group, is a bad character.
      if (pad_group_done) bump_err(b64sd_pkg::ST_BAD_CHAR);
      if (c == b64sd_pkg::CHAR_PAD) begin
        if (pos < 2'd2) bump_err(b64sd_pkg::ST_BAD_CHAR);
      end else begin
        if (!lk[6]) bump_err(b64sd_pkg::ST_BAD_CHAR);
        else v = lk[5:0];
        if (pos == 2'd3 && pad_at2) bump_err(b64sd_pkg::ST_BAD_CHAR);
      end
    end

    if (pos == 2'd3) begin
      grp = {sextets, v};
      nbytes = 3;
      padded = 1'b0;
      if (!url_sel) begin
        if (c == b64sd_pkg::CHAR_PAD) begin
          padded = 1'b1;
          if (pad_at2) begin
            nbytes = 1;
            if (sextets[9:6] != 4'd0) bump_err(b64sd_pkg::ST_NONCANON);
          end else begin
            nbytes = 2;
            if (sextets[1:0] != 2'd0) bump_err(b64sd_pkg::ST_NONCANON);
          end
        end else if (pad_at2) begin
          padded = 1'b1;
        end
      end
      if (text_err == b64sd_pkg::ST_OK) begin
        step_words[n] = {b64sd_pkg::KIND_DATA, grp[23:16], b64sd_pkg::ST_OK, 1'b0};
        n++;
        if (nbytes >= 2) begin
          step_words[n] = {b64sd_pkg::KIND_DATA, grp[15:8], b64sd_pkg::ST_OK, 1'b0};
          n++;
        end
        if (nbytes >= 3) begin
          step_words[n] = {b64sd_pkg::KIND_DATA, grp[7:0], b64sd_pkg::ST_OK, 1'b0};
          n++;
        end
      end
      if (padded) pad_group_done = 1'b1;
      sextets = 18'd0;
      pad_at2 = 1'b0;
      grp_pos = 2'd0;
    end else begin
      if (!url_sel && c == b64sd_pkg::CHAR_PAD && pos == 2'd2) pad_at2 = 1'b1;
      sextets = {sextets[11:0], v};
      grp_pos = pos + 2'd1;
    end

    if (last) begin
      if (!url_sel) begin
        if (grp_pos != 2'd0) bump_err(b64sd_pkg::ST_BAD_LEN);
      end else if (grp_pos == 2'd1) begin
        bump_err(b64sd_pkg::ST_BAD_LEN);
      end else if (grp_pos == 2'd2) begin
        // Two-character URL tail: one byte, low four bits of the last sextet must be clear.
        if (sextets[3:0] != 4'd0) bump_err(b64sd_pkg::ST_NONCANON);
        if (text_err == b64sd_pkg::ST_OK) begin
          step_words[n] = {b64sd_pkg::KIND_DATA, sextets[11:4], b64sd_pkg::ST_OK, 1'b0};
          n++;
        end
      end else if (grp_pos == 2'd3) begin
        // Three-character URL tail: two bytes, low two bits of the last sextet clear.
        if (sextets[1:0] != 2'd0) bump_err(b64sd_pkg::ST_NONCANON);
        if (text_err == b64sd_pkg::ST_OK) begin
          step_words[n] = {b64sd_pkg::KIND_DATA, sextets[17:10], b64sd_pkg::ST_OK, 1'b0};
          n++;
          step_words[n] = {b64sd_pkg::KIND_DATA, sextets[9:2], b64sd_pkg::ST_OK, 1'b0};
          n++;
        end
      end
      step_words[n] = {b64sd_pkg::KIND_STATUS, 8'h00, text_err, 1'b1};
      n++;
      grp_pos = 2'd0;
      sextets = 18'd0;
      pad_at2 = 1'b0;
      text_err = b64sd_pkg::ST_OK;
      pad_group_done = 1'b0;
    end
    return n;
  endfunction

  // Presents one character word, waits for it to be taken and records what it should cause.
  // The sender works in bursts; a new burst may start after a gap of idle cycles.
  // Entered and left at a falling edge.
  task automatic send_char(input logic [7:0] c, input logic last, input logic typed,
                           input b64sd_pkg::status_t typed_status);
    int gap;
    int n;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
    end
    burst_left--;
    repeat (gap) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = c;
    s_axis_tlast  = last;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    n = decode_char(c, last);
    if (typed) begin
      decoded_q.push_back({b64sd_pkg::KIND_STATUS, 8'h00, typed_status, 1'b1});
    end else begin
      for (int i = 0; i < n; i++) decoded_q.push_back(step_words[i]);
    end
    chars_sent++;
    if (last) texts_sent++;
    @(negedge clk);
  endtask

  // The mode register is only written with the block idle: input dropped, every expected
  // word out, and a further drain wait for anything still in flight.
  task automatic set_mode(input logic m);
    s_axis_tvalid = 1'b0;
    while (decoded_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = m;
    @(negedge clk);
    cfg_we  = 1'b0;
    url_sel = m;
  endtask

  // Builds a random text in text_q: mostly well-formed texts of a few groups with the
  // tails each mode allows, and about three in ten broken in one of several ways.
  task automatic make_text(input logic url);
    int          groups;
    int          tail;
    int          pick;
    logic        canonical;
    logic [5:0]  s;
    break_kind_t how;
    text_q.delete();
    groups = $urandom_range(0, 3);
    if (url) begin
      pick = $urandom_range(0, 2);
      tail = (pick == 0) ? 0 : pick + 1;
    end else begin
      tail = $urandom_range(0, 2);
    end
    if (groups == 0 && tail == 0) groups = 1;
    repeat (groups * 4) text_q.push_back(char_for(6'($urandom_range(0, 63)), url));
    canonical = ($urandom_range(0, 7) != 0);
    s = 6'($urandom_range(0, 63));
    if (!url && tail == 1) begin
      // One pad: three characters, then '='.
      repeat (2) text_q.push_back(char_for(6'($urandom_range(0, 63)), url));
      if (canonical) s[1:0] = 2'd0;
      text_q.push_back(char_for(s, url));
      text_q.push_back(b64sd_pkg::CHAR_PAD);
    end else if (!url && tail == 2) begin
      // Two pads: two characters, then '=='.
      text_q.push_back(char_for(6'($urandom_range(0, 63)), url));
      if (canonical) s[3:0] = 4'd0;
      text_q.push_back(char_for(s, url));
      text_q.push_back(b64sd_pkg::CHAR_PAD);
      text_q.push_back(b64sd_pkg::CHAR_PAD);
    end else if (url && tail == 2) begin
      text_q.push_back(char_for(6'($urandom_range(0, 63)), url));
      if (canonical) s[3:0] = 4'd0;
      text_q.push_back(char_for(s, url));
    end else if (url && tail == 3) begin
      repeat (2) text_q.push_back(char_for(6'($urandom_range(0, 63)), url));
      if (canonical) s[1:0] = 2'd0;
      text_q.push_back(char_for(s, url));
    end

    if ($urandom_range(0, 9) < 3) begin
      how = break_kind_t'($urandom_range(0, 5));
      case (how)
        BREAK_NOISE: begin
          // Raw bytes over the whole range; this is what exercises every bit of the code.
          text_q.delete();
          repeat ($urandom_range(1, 8)) text_q.push_back(8'($urandom_range(0, 255)));
        end
        BREAK_BYTE: begin
          text_q[$urandom_range(0, text_q.size() - 1)] = 8'($urandom_range(0, 255));
        end
        BREAK_PAD: begin
          text_q[$urandom_range(0, text_q.size() - 1)] = b64sd_pkg::CHAR_PAD;
        end
        BREAK_EXTRA: begin
          text_q.push_back(char_for(6'($urandom_range(0, 63)), url));
        end
        BREAK_GROUP: begin
          // In standard mode a group after a padded one is a bad character.
          repeat (4) text_q.push_back(char_for(6'($urandom_range(0, 63)), url));
        end
        default: begin
          // The top two sextets spelled in the other alphabet.
          text_q[$urandom_range(0, text_q.size() - 1)] =
            char_for(6'(62 + $urandom_range(0, 1)), !url);
        end
      endcase
    end
  endtask

  // The receiver switches between stall styles over stretches of random length, so that
  // back-pressure lands on every phase of a group, with stretches of none at all.
  initial begin
    rx_style_t style;
    int        span;
    logic      flip;
    m_axis_tready = 1'b0;
    flip = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      style = rx_style_t'($urandom_range(0, 3));
      span = $urandom_range(20, 200);
      repeat (span) begin
        flip = ~flip;
        case (style)
          RX_ALWAYS:  m_axis_tready = 1'b1;
          RX_MOSTLY:  m_axis_tready = ($urandom_range(0, 3) != 0);
          RX_SPARSE:  m_axis_tready = ($urandom_range(0, 3) == 0);
          default:    m_axis_tready = flip;
        endcase
        @(negedge clk);
      end
    end
  end

  // Every word taken from the block is matched against the oldest expected word.
  always @(posedge clk) begin : result_check
    b64sd_pkg::result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (decoded_q.size() == 0) begin
        report("result word with nothing pending", 0, {m_axis_tuser, m_axis_tdata});
      end else begin
        want = decoded_q.pop_front();
        words_checked++;
        if (m_axis_tuser !== want.kind) report("kind", want.kind, m_axis_tuser);
        if (m_axis_tdata[7:0] !== want.data_byte)
          report("data byte", want.data_byte, m_axis_tdata[7:0]);
        if (m_axis_tdata[9:8] !== want.status)
          report("status", want.status, m_axis_tdata[9:8]);
        if (m_axis_tlast !== want.end_mark) report("end mark", want.end_mark, m_axis_tlast);
        if (m_axis_tdata[15:10] !== 6'd0) report("unused data bits", 0, m_axis_tdata[15:10]);
        if (want.kind == b64sd_pkg::KIND_STATUS && want.status != b64sd_pkg::ST_OK)
          bad_texts++;
      end
    end
  end

  initial begin
    int phase_start;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = 8'h00;
    s_axis_tlast   = 1'b0;
    cfg_we         = 1'b0;
    cfg_wdata      = 1'b0;
    rst            = 1'b1;
    url_sel        = MODE_STD;
    grp_pos        = 2'd0;
    sextets        = 18'd0;
    pad_at2        = 1'b0;
    text_err       = b64sd_pkg::ST_OK;
    pad_group_done = 1'b0;
    burst_left     = 0;
    mismatches     = 0;
    chars_sent     = 0;
    texts_sent     = 0;
    words_checked  = 0;
    bad_texts      = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed texts; the mode is rewritten whenever the table moves to the other one.
    for (int k = 0; k < $size(dir_table); k++) begin
      if (k == 0 || dir_table[k].mode != url_sel) set_mode(dir_table[k].mode);
      send_char(dir_table[k].code, dir_table[k].last, dir_table[k].typed, dir_table[k].status);
    end

    // Random texts in phases; the first two pin both modes, the rest pick one at random.
    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph == 0) set_mode(MODE_STD);
      else if (ph == 1) set_mode(MODE_URL);
      else set_mode(1'($urandom_range(0, 1)));
      phase_start = chars_sent;
      while (chars_sent - phase_start < PHASE_CHARS) begin
        make_text(url_sel);
        for (int k = 0; k < text_q.size(); k++)
          send_char(text_q[k], k == text_q.size() - 1, CHECK_PRED, b64sd_pkg::ST_OK);
      end
    end

    s_axis_tvalid = 1'b0;
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES * 2) @(posedge clk);

    $display("Decoded %0d texts (%0d characters) in both alphabets, %0d with an error status.",
             texts_sent, chars_sent, bad_texts);
    $display("Checked %0d output words field by field; %0d mismatches.",
             words_checked, mismatches);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/b64sd_pkg.sv
rtl/b64sd_core.sv
rtl/b64sd_outq.sv
rtl/base64_strict_stream_decoder.sv
sim/tb.sv
